### rtl/cbpe_pkg.sv
// Shared constants and types for the cubic B-spline point evaluator.
`timescale 1ns / 1ps
package cbpe_pkg;

  localparam int COORD_W    = 16;
  localparam int T_FRAC     = 16;
  localparam int NUM_POINTS = 4;
  localparam int NUM_AXES   = 3;
  localparam int IDX_W      = $clog2(NUM_POINTS);
  localparam int PACK_W     = NUM_AXES * COORD_W;

  localparam int U_W    = T_FRAC + 1;        // 1 - t, Q1.F
  localparam int SQ_W   = 2 * T_FRAC + 1;    // raw square / cube products
  localparam int TRI_W  = 2 * T_FRAC + 3;    // three times a raw product
  localparam int W_W    = T_FRAC + 2;        // basis weight, Q2.F
  localparam int PROD_W = W_W + 1 + COORD_W; // weight times coordinate
  localparam int ACC_W  = PROD_W + 2;        // sum of four products
  localparam int RES_W  = ACC_W - T_FRAC;    // rounded sum before clamp

  localparam logic [U_W-1:0]   T_ONE    = {1'b1, {T_FRAC{1'b0}}};
  localparam logic [SQ_W-1:0]  HALF_SQ  = SQ_W'(1) << (T_FRAC - 1);
  localparam logic [TRI_W-1:0] HALF_TRI = TRI_W'(1) << (T_FRAC - 1);
  localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (T_FRAC - 1);

  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

  typedef logic [PACK_W-1:0]                 point_t;
  typedef point_t [NUM_POINTS-1:0]           point_vec_t;
  typedef logic [W_W-1:0]                    weight_t;
  typedef weight_t [NUM_POINTS-1:0]          weight_vec_t;
  typedef logic signed [COORD_W-1:0]         coord_t;
  typedef coord_t [NUM_AXES-1:0]             coord_vec_t;

endpackage

### rtl/cubic_bspline_point_eval_top.sv
// Top level of the clamped cubic B-spline point evaluator.
//
//   channel   direction  handshake               payload
//   in_       request    in_valid / in_ready     in_t_param (Q0.16)
//   out_      result     out_valid / out_ready   out_point_x, out_point_y, out_point_z
//   cfg_      write      cfg_we                  cfg_index, cfg_wdata (packed x,y,z)
//
// Five register stages: squares, cubes, weights, products, sum/round/clamp.
// One request per cycle while in_ready is high; out_valid is the last stage's valid bit.
// Reset clears the control points and all stage valid bits.
// A stalled output holds every full stage; empty stages still take data,
// so bubbles close up and in_ready drops only when all stages are full.
`timescale 1ns / 1ps
module cubic_bspline_point_eval_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cbpe_pkg::T_FRAC-1:0]   in_t_param,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cbpe_pkg::COORD_W-1:0] out_point_x,
  output logic signed [cbpe_pkg::COORD_W-1:0] out_point_y,
  output logic signed [cbpe_pkg::COORD_W-1:0] out_point_z,
  input  logic                          cfg_we,
  input  logic [cbpe_pkg::IDX_W-1:0]    cfg_index,
  input  logic [cbpe_pkg::PACK_W-1:0]   cfg_wdata
);

  cbpe_pkg::point_vec_t  points;
  cbpe_pkg::weight_vec_t w_vec;
  cbpe_pkg::coord_vec_t  out_point;
  logic                  w_valid, w_ready;

  cbpe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .points    (points)
  );

  cbpe_weight u_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_t     (in_t_param),
    .w_valid  (w_valid),
    .w_ready  (w_ready),
    .w_out    (w_vec)
  );

  cbpe_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .w_valid   (w_valid),
    .w_ready   (w_ready),
    .w_in      (w_vec),
    .points    (points),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_point (out_point)
  );

  assign out_point_x = out_point[0];
  assign out_point_y = out_point[1];
  assign out_point_z = out_point[2];

  // Bernstein weights sum to one within a few units of rounding
  logic [cbpe_pkg::W_W+1:0] w_total;
  assign w_total = (cbpe_pkg::W_W+2)'(w_vec[0]) + (cbpe_pkg::W_W+2)'(w_vec[1])
                 + (cbpe_pkg::W_W+2)'(w_vec[2]) + (cbpe_pkg::W_W+2)'(w_vec[3]);

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid |-> (w_total >= (cbpe_pkg::W_W+2)'((1 << cbpe_pkg::T_FRAC) - 8)) &&
                (w_total <= (cbpe_pkg::W_W+2)'((1 << cbpe_pkg::T_FRAC) + 8)))
    else $error("basis weights do not sum to one");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output not blocked");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cfg_we) |-> points[$past(cfg_index)] == $past(cfg_wdata))
    else $error("control point write lost");

endmodule

### rtl/cbpe_cfg_regs.sv
// Control point register file written through the configuration port.
`timescale 1ns / 1ps
module cbpe_cfg_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cbpe_pkg::IDX_W-1:0]  cfg_index,
  input  logic [cbpe_pkg::PACK_W-1:0] cfg_wdata,
  output cbpe_pkg::point_vec_t     points
);

  cbpe_pkg::point_vec_t pts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0;
    end else if (cfg_we) begin
      pts_r[cfg_index] <= cfg_wdata;
    end
  end

  assign points = pts_r;

endmodule

### rtl/cbpe_weight.sv
// Three-stage pipeline producing the four cubic basis weights from t.
`timescale 1ns / 1ps
module cbpe_weight (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cbpe_pkg::T_FRAC-1:0] in_t,
  output logic                        w_valid,
  input  logic                        w_ready,
  output cbpe_pkg::weight_vec_t       w_out
);

  localparam int F = cbpe_pkg::T_FRAC;

  // stage 1: squares
  logic                            v1_r;
  logic [F-1:0]                    t1_r;
  logic [cbpe_pkg::U_W-1:0]        u1_r;
  logic [cbpe_pkg::SQ_W-1:0]       uu_p_r, tt_p_r;
  // stage 2: cubes
  logic                            v2_r;
  logic [cbpe_pkg::SQ_W-1:0]       uuu_p_r, uut_p_r, ttu_p_r, ttt_p_r;
  // stage 3: rounded weights
  logic                            v3_r;
  cbpe_pkg::weight_vec_t           w_r;

  logic                            rdy1, rdy2, rdy3;
  logic [cbpe_pkg::U_W-1:0]        u_nxt;
  logic [cbpe_pkg::SQ_W-1:0]       uu_sum, tt_sum;
  logic [cbpe_pkg::U_W-1:0]        uu, tt;
  logic [cbpe_pkg::SQ_W-1:0]       w0_sum, w3_sum;
  logic [cbpe_pkg::TRI_W-1:0]      w1_sum, w2_sum;
  cbpe_pkg::weight_vec_t           w_nxt;

  assign rdy3     = !v3_r || w_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign u_nxt  = cbpe_pkg::T_ONE - {1'b0, in_t};

  assign uu_sum = uu_p_r + cbpe_pkg::HALF_SQ;
  assign tt_sum = tt_p_r + cbpe_pkg::HALF_SQ;
  assign uu     = uu_sum[2*F:F];
  assign tt     = tt_sum[2*F:F];

  // times three as shift plus add, then round
  assign w0_sum = uuu_p_r + cbpe_pkg::HALF_SQ;
  assign w3_sum = ttt_p_r + cbpe_pkg::HALF_SQ;
  assign w1_sum = cbpe_pkg::TRI_W'({uut_p_r, 1'b0}) + cbpe_pkg::TRI_W'(uut_p_r)
                + cbpe_pkg::HALF_TRI;
  assign w2_sum = cbpe_pkg::TRI_W'({ttu_p_r, 1'b0}) + cbpe_pkg::TRI_W'(ttu_p_r)
                + cbpe_pkg::HALF_TRI;

  always_comb begin
    w_nxt[0] = cbpe_pkg::W_W'(w0_sum[2*F:F]);
    w_nxt[1] = w1_sum[2*F+1:F];
    w_nxt[2] = w2_sum[2*F+1:F];
    w_nxt[3] = cbpe_pkg::W_W'(w3_sum[2*F:F]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      t1_r   <= in_t;
      u1_r   <= u_nxt;
      uu_p_r <= cbpe_pkg::SQ_W'(u_nxt) * cbpe_pkg::SQ_W'(u_nxt);
      tt_p_r <= cbpe_pkg::SQ_W'(in_t) * cbpe_pkg::SQ_W'(in_t);
    end
    if (rdy2 && v1_r) begin
      uuu_p_r <= cbpe_pkg::SQ_W'(uu) * cbpe_pkg::SQ_W'(u1_r);
      uut_p_r <= cbpe_pkg::SQ_W'(uu) * cbpe_pkg::SQ_W'(t1_r);
      ttu_p_r <= cbpe_pkg::SQ_W'(tt) * cbpe_pkg::SQ_W'(u1_r);
      ttt_p_r <= cbpe_pkg::SQ_W'(tt) * cbpe_pkg::SQ_W'(t1_r);
    end
    if (rdy3 && v2_r) begin
      w_r <= w_nxt;
    end
  end

  assign w_valid = v3_r;
  assign w_out   = w_r;

endmodule

### rtl/cbpe_blend.sv
// Two-stage blend: weight times control point, then sum, round and clamp.
`timescale 1ns / 1ps
module cbpe_blend (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   w_valid,
  output logic                   w_ready,
  input  cbpe_pkg::weight_vec_t  w_in,
  input  cbpe_pkg::point_vec_t   points,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cbpe_pkg::coord_vec_t   out_point
);

  localparam int F = cbpe_pkg::T_FRAC;
  localparam int C = cbpe_pkg::COORD_W;

  logic                                   pv_r;
  logic signed [cbpe_pkg::PROD_W-1:0]     prod_r [cbpe_pkg::NUM_AXES][cbpe_pkg::NUM_POINTS];
  logic signed [cbpe_pkg::PROD_W-1:0]     prod_nxt [cbpe_pkg::NUM_AXES][cbpe_pkg::NUM_POINTS];
  logic                                   ov_r;
  cbpe_pkg::coord_vec_t                   pt_r;
  cbpe_pkg::coord_vec_t                   pt_nxt;
  logic                                   rdy_p, rdy_o;

  assign rdy_o   = !ov_r || out_ready;
  assign rdy_p   = !pv_r || rdy_o;
  assign w_ready = rdy_p;

  always_comb begin
    logic signed [cbpe_pkg::W_W:0] ws;
    logic signed [C-1:0]           cs;
    for (int a = 0; a < cbpe_pkg::NUM_AXES; a++) begin
      for (int k = 0; k < cbpe_pkg::NUM_POINTS; k++) begin
        ws = $signed({1'b0, w_in[k]});
        cs = $signed(points[k][a*C +: C]);
        prod_nxt[a][k] = cbpe_pkg::PROD_W'(ws) * cbpe_pkg::PROD_W'(cs);
      end
    end
  end

  always_comb begin
    logic signed [cbpe_pkg::ACC_W-1:0] acc;
    logic signed [cbpe_pkg::RES_W-1:0] res;
    for (int a = 0; a < cbpe_pkg::NUM_AXES; a++) begin
      acc = cbpe_pkg::HALF_ACC;
      for (int k = 0; k < cbpe_pkg::NUM_POINTS; k++) begin
        acc = acc + cbpe_pkg::ACC_W'(prod_r[a][k]);
      end
      // drop the fraction: floor, so exact halves go up for either sign
      res = acc[cbpe_pkg::ACC_W-1:F];
      if (res > cbpe_pkg::SAT_MAX) begin
        pt_nxt[a] = cbpe_pkg::SAT_MAX[C-1:0];
      end else if (res < cbpe_pkg::SAT_MIN) begin
        pt_nxt[a] = cbpe_pkg::SAT_MIN[C-1:0];
      end else begin
        pt_nxt[a] = res[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy_p) begin
        pv_r <= w_valid;
      end
      if (rdy_o) begin
        ov_r <= pv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_p && w_valid) begin
      prod_r <= prod_nxt;
    end
    if (rdy_o && pv_r) begin
      pt_r <= pt_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_point = pt_r;

endmodule

### sim/cubic_bspline_point_eval_top_tb.sv
// Self-checking testbench for the cubic B-spline point evaluator top level.
`timescale 1ns / 1ps
module cubic_bspline_point_eval_top_tb;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 125;

  class curve_point_scoreboard;
    cbpe_pkg::point_vec_t  ctrl_pts;
    cbpe_pkg::coord_vec_t  pending_points[$];
    int unsigned mismatches;

    function new();
      ctrl_pts = '0;
      mismatches = 0;
    endfunction

    function void set_point(int idx, cbpe_pkg::point_t value);
      ctrl_pts[idx] = value;
    endfunction

    function int pending();
      return pending_points.size();
    endfunction

    // Bernstein-weighted blend of the control points, round-half-up, clamped.
    function cbpe_pkg::coord_vec_t blend_point(logic [cbpe_pkg::T_FRAC-1:0] t);
      longint unsigned      tq, uq, uu, tt, half;
      longint signed        w [cbpe_pkg::NUM_POINTS];
      longint signed        acc, r;
      cbpe_pkg::coord_t     c;
      cbpe_pkg::coord_vec_t res;
      half = longint'(1) << (cbpe_pkg::T_FRAC - 1);
      tq = t;
      uq = (longint'(1) << cbpe_pkg::T_FRAC) - tq;
      uu = (uq * uq + half) >> cbpe_pkg::T_FRAC;
      tt = (tq * tq + half) >> cbpe_pkg::T_FRAC;
      w[0] = longint'((uu * uq + half) >> cbpe_pkg::T_FRAC);
      w[1] = longint'((3 * uu * tq + half) >> cbpe_pkg::T_FRAC);
      w[2] = longint'((3 * tt * uq + half) >> cbpe_pkg::T_FRAC);
      w[3] = longint'((tt * tq + half) >> cbpe_pkg::T_FRAC);
      for (int axis = 0; axis < cbpe_pkg::NUM_AXES; axis++) begin
        acc = 0;
        for (int k = 0; k < cbpe_pkg::NUM_POINTS; k++) begin
          c = ctrl_pts[k][axis*cbpe_pkg::COORD_W +: cbpe_pkg::COORD_W];
          acc += w[k] * longint'(c);
        end
        r = (acc + longint'(half)) >>> cbpe_pkg::T_FRAC;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        res[axis] = cbpe_pkg::coord_t'(r);
      end
      return res;
    endfunction

    function void note_request(logic [cbpe_pkg::T_FRAC-1:0] t);
      pending_points.insert(pending_points.size(), blend_point(t));
    endfunction

    function void check_point(cbpe_pkg::coord_t x, cbpe_pkg::coord_t y,
                              cbpe_pkg::coord_t z);
      cbpe_pkg::coord_vec_t exp_pt;
      cbpe_pkg::coord_vec_t got;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time, x, y, z);
        mismatches++;
        return;
      end
      exp_pt = pending_points.pop_front();
      got = {z, y, x};
      for (int axis = 0; axis < cbpe_pkg::NUM_AXES; axis++) begin
        if (got[axis] !== exp_pt[axis]) begin
          $display("%0t: axis %0d expected %0d actual %0d", $time, axis,
                   exp_pt[axis], got[axis]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [cbpe_pkg::T_FRAC-1:0]     in_t_param;
  logic                            out_valid;
  logic                            out_ready;
  cbpe_pkg::coord_t                out_point_x;
  cbpe_pkg::coord_t                out_point_y;
  cbpe_pkg::coord_t                out_point_z;
  logic                            cfg_we;
  logic [cbpe_pkg::IDX_W-1:0]      cfg_index;
  logic [cbpe_pkg::PACK_W-1:0]     cfg_wdata;

  curve_point_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int unsigned cycle_count;

  cubic_bspline_point_eval_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_t_param  (in_t_param),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_point_z (out_point_z),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_point(out_point_x, out_point_y, out_point_z);
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_request(input logic [cbpe_pkg::T_FRAC-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_t_param <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_request(t);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_points(input cbpe_pkg::point_vec_t pts);
    for (int i = 0; i < cbpe_pkg::NUM_POINTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cbpe_pkg::IDX_W'(i);
      cfg_wdata <= pts[i];
      sb.set_point(i, pts[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic cbpe_pkg::coord_t pick_coord();
    case ($urandom_range(3))
      0:       return cbpe_pkg::coord_t'(16'sh8000);
      1:       return cbpe_pkg::coord_t'(16'sh7FFF);
      default: return cbpe_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [cbpe_pkg::T_FRAC-1:0] pick_t();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return cbpe_pkg::T_FRAC'(1);
      3:       return cbpe_pkg::T_FRAC'(16'h8000);
      default: return cbpe_pkg::T_FRAC'($urandom);
    endcase
  endfunction

  function automatic cbpe_pkg::point_vec_t uniform_points(cbpe_pkg::coord_t c);
    cbpe_pkg::point_vec_t pts;
    for (int i = 0; i < cbpe_pkg::NUM_POINTS; i++) pts[i] = {c, c, c};
    return pts;
  endfunction

  initial begin
    logic [cbpe_pkg::T_FRAC-1:0] dir_t [9];
    cbpe_pkg::point_vec_t        pts;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_t_param = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    dir_t = '{16'h0000, 16'h0001, 16'h0002, 16'h4000, 16'h7FFF,
              16'h8000, 16'hC000, 16'hFFFE, 16'hFFFF};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Control points still at reset.
    send_request(16'h0000);
    send_request(16'hFFFF);
    wait_drained();

    // All coordinates at the positive limit: rounding may push past it.
    write_points(uniform_points(cbpe_pkg::coord_t'(16'sh7FFF)));
    for (int i = 0; i < 5; i++) send_request(dir_t[2*i]);
    wait_drained();

    write_points(uniform_points(cbpe_pkg::coord_t'(16'sh8000)));
    for (int i = 0; i < 5; i++) send_request(dir_t[2*i]);
    wait_drained();

    pts[0] = {16'sh0000, 16'sh7FFF, 16'sh8000};
    pts[1] = {16'sh0001, 16'sh8000, 16'sh7FFF};
    pts[2] = {16'sh8000, 16'sh0000, 16'shFFFF};
    pts[3] = {16'sh8000, 16'sh7FFF, 16'sh7FFF};
    write_points(pts);
    for (int i = 0; i < 9; i++) send_request(dir_t[i]);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 30; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < cbpe_pkg::NUM_POINTS; i++)
        pts[i] = {pick_coord(), pick_coord(), pick_coord()};
      write_points(pts);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off until the pipeline has emptied once per phase
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_request(pick_t());
      end
      wait_drained();
    end

    repeat (12) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cbpe_pkg.sv
rtl/cbpe_cfg_regs.sv
rtl/cbpe_weight.sv
rtl/cbpe_blend.sv
rtl/cubic_bspline_point_eval_top.sv
sim/cubic_bspline_point_eval_top_tb.sv
